@@ hw/rtl/deft_pkg.sv @@
`timescale 1ns / 1ps
package deft_pkg;

  // Ring geometry
  localparam int CACHE_DEPTH = 32;
  localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CNT_W = $clog2(CACHE_DEPTH + 1);

  // Field widths
  localparam int SENDER_W = 64;
  localparam int SEQ_W    = 32;
  localparam int MS_W     = 32;

  localparam logic [MS_W-1:0] TTL_RESET = MS_W'(60000);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One remembered event
  typedef struct packed {
    logic [SENDER_W-1:0] sender;
    logic [SEQ_W-1:0]    seq;
    logic [MS_W-1:0]     stamp;
  } entry_t;

  // Ring slot at a given offset from a base slot; offset never exceeds the depth
  function automatic idx_t slot_add(input idx_t base, input cnt_t offset);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
    if (sum >= (CNT_W + 1)'(CACHE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(CACHE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ hw/rtl/duplicate_event_filter_ttl.sv @@
`timescale 1ns / 1ps
// Duplicate event filter with time-to-live.
// Input channel (in_valid/in_ready): one event with sender, sequence and the
// current millisecond time. Result channel (out_valid/out_ready): one
// is_duplicate flag per event, in order. cfg_we/cfg_wdata write ttl_ms.
// Events are remembered in a ring held in one synchronous memory. Each event
// walks the live entries from the oldest end: while entries are aged past
// ttl_ms they are retired, after that each entry is compared with the event.
// The walk reads one entry per cycle through the memory's single read port.
// An event with an empty sender goes straight to the result; an event that
// meets an empty ring is appended and then reported; otherwise the walk runs
// over the live entries, a match ending it early, and an event with no match
// is appended after the walk. One event is processed at a time; the next
// transfer is taken once the previous result has entered the output register.
// Reset empties the ring (no clearing pass: entry count and oldest slot go to
// zero) and sets ttl_ms to 60000. When the receiver stalls, the result is held
// in the output register; a further event may still be processed and then
// waits for that register to free up.
module duplicate_event_filter_ttl
  import deft_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_sender_present,
  input  logic [SENDER_W-1:0] in_sender_id,
  input  logic [SEQ_W-1:0]    in_event_seq,
  input  logic [MS_W-1:0]     in_now_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_is_duplicate,
  input  logic                cfg_we,
  input  logic [MS_W-1:0]     cfg_wdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam cnt_t ONE   = CNT_W'(1);
  localparam cnt_t DEPTH = CNT_W'(CACHE_DEPTH);

  // Entry memory
  entry_t mem [CACHE_DEPTH];
  entry_t rd_data_r;
  logic   rd_en;
  idx_t   rd_addr;
  logic   wr_en;
  idx_t   wr_addr;
  entry_t wr_data;

  // Control state
  logic [1:0]      state_r, state_nxt;
  idx_t            oldest_r, oldest_nxt;
  cnt_t            count_r, count_nxt;
  logic [MS_W-1:0] ttl_r;
  idx_t            base_r, base_nxt;
  cnt_t            total_r, total_nxt;
  cnt_t            iss_r, iss_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  cnt_t            chk_k_r, chk_k_nxt;
  logic            aging_r, aging_nxt;
  logic            dup_r, dup_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_dup_r, out_dup_nxt;

  // Held event
  logic [SENDER_W-1:0] sender_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [MS_W-1:0]     now_r;

  logic            in_xfer;
  logic [MS_W-1:0] age;
  logic            expired;
  logic            hit;
  logic            last_chk;

  assign in_ready         = (state_r == S_IDLE);
  assign in_xfer          = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_is_duplicate = out_dup_r;

  // Check the entry that arrived from memory
  assign age      = now_r - rd_data_r.stamp;
  assign expired  = chk_vld_r && aging_r && (age > ttl_r);
  assign hit      = chk_vld_r && !expired && (rd_data_r.sender == sender_r) &&
                    (rd_data_r.seq == seq_r);
  assign last_chk = chk_vld_r && (chk_k_r == total_r - ONE);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    base_nxt      = base_r;
    total_nxt     = total_r;
    iss_nxt       = iss_r;
    chk_vld_nxt   = 1'b0;
    chk_k_nxt     = chk_k_r;
    aging_nxt     = aging_r;
    dup_nxt       = dup_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_dup_nxt   = out_dup_r;
    rd_en         = 1'b0;
    rd_addr       = slot_add(base_r, iss_r);
    wr_en         = 1'b0;
    wr_addr       = slot_add(oldest_r, count_r);
    wr_data       = '{sender: sender_r, seq: seq_r, stamp: now_r};

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          base_nxt  = oldest_r;
          total_nxt = count_r;
          iss_nxt   = '0;
          aging_nxt = 1'b1;
          dup_nxt   = 1'b0;
          if (!in_sender_present) begin
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // retire aged entries from the oldest end, then compare
        if (expired) begin
          oldest_nxt = slot_add(oldest_r, ONE);
          count_nxt  = count_r - ONE;
        end else if (chk_vld_r) begin
          aging_nxt = 1'b0;
        end
        if (hit) begin
          dup_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          if (iss_r < total_r) begin
            rd_en       = 1'b1;
            iss_nxt     = iss_r + ONE;
            chk_vld_nxt = 1'b1;
            chk_k_nxt   = iss_r;
          end
          if (last_chk) begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        // append, displacing the oldest entry when full
        wr_en = 1'b1;
        if (count_r == DEPTH) begin
          wr_addr    = oldest_r;
          oldest_nxt = slot_add(oldest_r, ONE);
        end else begin
          count_nxt = count_r + ONE;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dup_nxt   = dup_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      ttl_r       <= TTL_RESET;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        ttl_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    total_r   <= total_nxt;
    iss_r     <= iss_nxt;
    chk_k_r   <= chk_k_nxt;
    aging_r   <= aging_nxt;
    dup_r     <= dup_nxt;
    out_dup_r <= out_dup_nxt;
    if (in_xfer) begin
      sender_r <= in_sender_id;
      seq_r    <= in_event_seq;
      now_r    <= in_now_ms;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH)
    else $error("entry count beyond ring depth");

  a_write_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |=> count_r != '0)
    else $error("ring empty after append");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside completion");

  a_check_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> state_r == S_SCAN)
    else $error("memory check pending outside scan");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb
  import deft_pkg::*;
();

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 300;
  localparam int NUM_PHASES = 6;

  // One event as offered on the input channel
  typedef struct {
    bit                  present;
    logic [SENDER_W-1:0] sender;
    logic [SEQ_W-1:0]    seq;
    logic [MS_W-1:0]     now;
  } radio_msg_t;

  // Recent-seen cache mirror and the queue of duplicate flags still owed
  class dup_scoreboard;
    logic [SENDER_W-1:0] sender_mem [CACHE_DEPTH];
    logic [SEQ_W-1:0]    seq_mem    [CACHE_DEPTH];
    logic [MS_W-1:0]     stamp_mem  [CACHE_DEPTH];
    int unsigned         head;
    int unsigned         live;
    logic [MS_W-1:0]     ttl;
    bit                  expected_flags[$];
    int                  errors;

    function new();
      head = 0;
      live = 0;
      ttl = TTL_RESET;
      errors = 0;
    endfunction

    // Update the cache for one event and return whether it was seen recently
    function bit seen_recently(radio_msg_t m);
      int unsigned    slot;
      int unsigned    i;
      logic [MS_W-1:0] age;
      if (!m.present) begin
        return 1'b0;
      end
      // retire aged entries from the oldest end
      while (live > 0) begin
        age = m.now - stamp_mem[head];
        if (age <= ttl) begin
          break;
        end
        head = (head + 1) % CACHE_DEPTH;
        live--;
      end
      // search live entries for the same sender and sequence
      for (i = 0; i < live; i++) begin
        slot = (head + i) % CACHE_DEPTH;
        if (sender_mem[slot] == m.sender && seq_mem[slot] == m.seq) begin
          return 1'b1;
        end
      end
      // drop the oldest when full, then append
      if (live >= CACHE_DEPTH) begin
        head = (head + 1) % CACHE_DEPTH;
        live--;
      end
      slot = (head + live) % CACHE_DEPTH;
      sender_mem[slot] = m.sender;
      seq_mem[slot] = m.seq;
      stamp_mem[slot] = m.now;
      live++;
      return 1'b0;
    endfunction

    function void note_event(radio_msg_t m);
      expected_flags.push_back(seen_recently(m));
    endfunction

    function void check_flag(logic got);
      bit want;
      if (expected_flags.size() == 0) begin
        errors++;
        $display("%0t: is_duplicate expected none got %0b", $time, got);
        return;
      end
      want = expected_flags.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: is_duplicate expected %0b got %0b", $time, want, got);
      end
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_sender_present;
  logic [SENDER_W-1:0] in_sender_id;
  logic [SEQ_W-1:0]    in_event_seq;
  logic [MS_W-1:0]     in_now_ms;
  logic                out_valid;
  logic                out_ready;
  logic                out_is_duplicate;
  logic                cfg_we;
  logic [MS_W-1:0]     cfg_wdata;

  dup_scoreboard       sb;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  int                  hold_req_cnt;
  int                  stall_cycles;
  logic [MS_W-1:0]     clock_ms;
  int unsigned         max_step;
  logic [SENDER_W-1:0] callsigns [8];

  duplicate_event_filter_ttl DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sender_present(in_sender_present),
    .in_sender_id     (in_sender_id),
    .in_event_seq     (in_event_seq),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_duplicate (out_is_duplicate),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Count cycles without any transfer on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("duplicate_event_filter_ttl verification failed");
    $finish;
  end

  // Result side: check each transfer, then pick the next ready level
  initial begin : result_side
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        sb.check_flag(out_is_duplicate);
      end
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one event and hold it until the transfer
  task automatic send_msg(input radio_msg_t m);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sender_present <= m.present;
    in_sender_id <= m.sender;
    in_event_seq <= m.seq;
    in_now_ms <= m.now;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sb.note_event(m);
  endtask

  // Stop offering and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending() != 0);
  endtask

  task automatic write_ttl(input logic [MS_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    sb.ttl = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic radio_msg_t mk_msg(bit present, logic [SENDER_W-1:0] sender,
                                        logic [SEQ_W-1:0] seq, logic [MS_W-1:0] now);
    radio_msg_t m;
    m.present = present;
    m.sender = sender;
    m.seq = seq;
    m.now = now;
    return m;
  endfunction

  // Mostly a few callsigns and low sequences so repeats are common
  function automatic radio_msg_t random_msg();
    radio_msg_t  m;
    int unsigned pick;
    m.present = ($urandom_range(0, 99) >= 5);
    m.sender = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                           : callsigns[$urandom_range(0, 7)];
    m.seq = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 11);
    // advance time; now and then step back or jump anywhere
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      clock_ms = clock_ms - $urandom_range(1, max_step);
    end else if (pick < 5) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, max_step);
    end
    m.now = clock_ms;
    return m;
  endfunction

  initial begin : stimulus
    logic [MS_W-1:0] ttl_plan [NUM_PHASES];
    int unsigned     step_plan [NUM_PHASES];
    int              n;
    sb = new();
    callsigns[0] = "W1AW";
    callsigns[1] = "K2ABC";
    callsigns[2] = "VE3XYZ";
    callsigns[3] = "JA1ZZZ";
    callsigns[4] = "DL0ABCDE";
    callsigns[5] = "G4A";
    callsigns[6] = '0;
    callsigns[7] = '1;
    ttl_plan = '{32'd60000, 32'd0, 32'hFFFF_FFFF, 32'd100, 32'd1, 32'd5000};
    step_plan = '{1500, 1, 32'h4000_0000, 8, 1, 300};
    hold_req_cnt = 0;
    send_idle_pct = 27;
    recv_idle_pct = 74;
    clock_ms = '0;
    max_step = 1;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sender_present <= 1'b0;
    in_sender_id <= '0;
    in_event_seq <= '0;
    in_now_ms <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty sender, TTL boundary, time going back, extremes
    send_msg(mk_msg(1'b0, '1, '1, '1));
    send_msg(mk_msg(1'b1, '1, '1, 32'd0));
    send_msg(mk_msg(1'b1, '1, '1, 32'd0));
    send_msg(mk_msg(1'b1, '1, '1, 32'd60000));
    send_msg(mk_msg(1'b1, '1, '1, 32'd60001));
    send_msg(mk_msg(1'b1, '0, '0, 32'd60001));
    send_msg(mk_msg(1'b1, '0, '0, 32'd60000));
    send_msg(mk_msg(1'b0, '0, '0, 32'd60000));
    send_msg(mk_msg(1'b1, '0, '0, 32'd60000));
    drain();
    write_ttl(32'd0);
    send_msg(mk_msg(1'b1, callsigns[0], 32'd5, 32'd1000));
    send_msg(mk_msg(1'b1, callsigns[0], 32'd5, 32'd1000));
    send_msg(mk_msg(1'b1, callsigns[0], 32'd5, 32'd1001));
    write_ttl('1);
    send_msg(mk_msg(1'b1, callsigns[0], 32'd5, 32'd0));
    send_msg(mk_msg(1'b1, callsigns[1], 32'd5, 32'd0));
    send_msg(mk_msg(1'b1, callsigns[0], 32'd6, 32'h8000_0000));
    send_msg(mk_msg(1'b1, callsigns[1], '1, '1));

    // Random phases, each under its own TTL and time step
    n = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_ttl(ttl_plan[p]);
      max_step = step_plan[p];
      if (ttl_plan[p] == 32'd5000) begin
        clock_ms = 32'hFFFF_F000;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (n < 600) begin
          send_idle_pct = 27;
          recv_idle_pct = 74;
        end else if (n < 1200) begin
          send_idle_pct = 74;
          recv_idle_pct = 27;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (n == 50 || n == 1300) begin
          hold_req_cnt++;
        end
        send_msg(random_msg());
        n++;
      end
    end

    // Wait out the tail and report
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("duplicate_event_filter_ttl verification clean");
    end else begin
      $display("duplicate_event_filter_ttl verification failed");
    end
    $finish;
  end

endmodule
